[rtl/core/lpf_pkg.sv]
// lpf_pkg: shared types and constants for the lookahead path follower
// no dependencies; imported by lpf_sqrt, lpf_div and lookahead_path_follower
package lpf_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned CfgW   = 19;

  typedef enum logic [2:0] {
    REG_LA_BASE  = 3'd0,
    REG_LA_MIN   = 3'd1,
    REG_LA_MAX   = 3'd2,
    REG_SPD_MAX  = 3'd3,
    REG_SPD_MIN  = 3'd4,
    REG_ADAPTIVE = 3'd5
  } cfg_reg_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_POSE = 1'b1;

  // end nearer than 0.5 m and target nearer than 1 mm
  localparam logic [63:0] END_NEAR  = 64'd32768;
  localparam logic [63:0] STOP_NEAR = 64'd66;

  // divide by five as multiply and shift by 24, exact below 2^22;
  // at or past the limit the fifth alone exceeds any 19-bit clamp
  localparam logic [21:0] FIFTH_MUL   = 22'd3355444;
  localparam logic [63:0] FIFTH_LIMIT = 64'd2621440;

  typedef struct packed {
    logic                     operation;
    logic [7:0]               point_index;
    logic                     point_last;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
  } in_item_t;

  typedef struct packed {
    logic                     valid_res;
    logic signed [CoordW-1:0] vel_x;
    logic signed [CoordW-1:0] vel_y;
    logic [30:0]              distance_to_end;
  } out_item_t;

  // request to a multi-cycle arithmetic unit
  typedef struct packed {
    logic         go;
    logic [127:0] a;
    logic [63:0]  b;
  } unit_req_t;

endpackage

[rtl/core/lpf_ram.sv]
// lpf_ram: generic single-port ram with registered read
// no dependencies
module lpf_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: read data is registered, valid in the next cycle, old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

[rtl/core/lpf_sqrt.sv]
// lpf_sqrt: bit-serial integer square root of a 65-bit value, one result bit per cycle
// depends on lpf_pkg
module lpf_sqrt import lpf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  unit_req_t   req,
  output logic        done,
  output logic [63:0] root
);
  // operand prescaled: a sum of 2^64 or more is taken as sum/4 and doubled
  logic [65:0] rem;
  logic [65:0] val;
  logic [32:0] r;
  logic [5:0]  cnt;
  logic        busy;
  logic        dbl;
  logic [65:0] trial;
  logic [65:0] rem_sh;

  assign rem_sh = {rem[63:0], val[65:64]};
  assign trial  = {31'd0, r, 2'b01};

  // restoring root, two operand bits per step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
        dbl  <= req.a[64];
        val  <= req.a[64] ? {2'b00, req.a[64:2]} : {1'b0, req.a[64:0]};
        rem  <= '0;
        r    <= '0;
        cnt  <= 6'd33;
      end else if (busy) begin
        val <= {val[63:0], 2'b00};
        if (rem_sh >= trial) begin
          rem <= rem_sh - trial;
          r   <= {r[31:0], 1'b1};
        end else begin
          rem <= rem_sh;
          r   <= {r[31:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = dbl ? {30'd0, r, 1'b0} : {31'd0, r};
endmodule

[rtl/core/lpf_div.sv]
// lpf_div: radix-2 restoring divider, 96-bit dividend by 64-bit divisor
// depends on lpf_pkg
module lpf_div import lpf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  unit_req_t   req,
  output logic        done,
  output logic [95:0] quot
);
  logic [64:0] rem;
  logic [63:0] dvs;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] sh;

  assign sh = {rem[63:0], quot[95]};

  // one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
        quot <= req.a[95:0];
        dvs  <= req.b;
        rem  <= '0;
        cnt  <= 7'd96;
      end else if (busy) begin
        if (sh >= {1'b0, dvs}) begin
          rem  <= sh - {1'b0, dvs};
          quot <= {quot[94:0], 1'b1};
        end else begin
          rem  <= sh;
          quot <= {quot[94:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[rtl/core/lookahead_path_follower.sv]
// lookahead_path_follower: top level, waypoint memory and control sequencer
// depends on lpf_pkg, lpf_ram, lpf_sqrt, lpf_div
//
//  channel  signals                                    beat taken when
//  input    start, busy, in_item                       start && !busy
//  result   res_strobe, res_item                       res_strobe (no stall)
//  config   cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid && cfg_ready
//
// a load stores a waypoint if its index is in range; a pose scans the n waypoints
// for the nearest, takes its distance and the distance to the end by sqrt, walks
// segments from the nearest (two reads, squares and a sqrt each), then up to two
// divides place the target, a sqrt gives its distance and up to two divides the
// velocity. the single memory port and the serial sqrt and divide set the pace.
// rst is synchronous; registers return to their reset values, path empty.
// the result strobe lasts one cycle; busy stays high until it has gone.
module lookahead_path_follower import lpf_pkg::*; #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  in_item_t                      in_item,
  output logic                          res_strobe,
  output out_item_t                     res_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [31:0]                   cfg_data
);
  localparam int unsigned AW = (MAX_POINTS > 256) ? $clog2(MAX_POINTS) : 8;
  localparam int unsigned LW = AW + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_WT, S_SCAN_CMP, S_NEAR_SQ, S_NEAR_WT,
    S_END_RD, S_END_WT, S_END_SQ, S_END_DONE,
    S_WALK_RD0, S_WALK_WT0, S_WALK_RD1, S_WALK_WT1, S_SEG_SQ, S_SEG_CHK,
    S_IX_DIV, S_IY_DIV, S_ERR_SQ, S_ERR_CHK, S_VX_DIV, S_VY_DIV, S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [CfgW-1:0] la_base, la_min, la_max, spd_max, spd_min;
  logic            adaptive;
  logic [LW-1:0]   point_count;

  assign cfg_ready = 1'b1;

  // memory port
  logic            we;
  logic [AW-1:0]   addr;
  logic [63:0]     wdata, rdata;

  lpf_ram #(.WIDTH(64), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // arithmetic units
  unit_req_t   sq_req, dv_req;
  logic        sq_done, dv_done;
  logic [63:0] sq_root;
  logic [95:0] dv_quot;

  lpf_sqrt u_sqrt (.clk(clk), .rst(rst), .req(sq_req), .done(sq_done), .root(sq_root));
  lpf_div  u_div  (.clk(clk), .rst(rst), .req(dv_req), .done(dv_done), .quot(dv_quot));

  // working registers
  logic signed [31:0] cx, cy, px, py;
  logic signed [32:0] tx, ty;
  logic [LW-1:0]      idx, last, nearest;
  logic [64:0]        best;
  logic [63:0]        dmin, dend, la, cum, seg, derr;
  logic [CfgW-1:0]    spd, rem_la;
  logic               first;
  logic signed [33:0] ddx, ddy;
  logic [33:0]        adx, ady;
  logic [65:0]        sqx, sqy;
  logic [1:0]         mpass;
  logic               neg;

  // magnitude of a signed difference pair, whose squares give the squared distance
  function automatic logic [33:0] mag(input logic signed [33:0] v);
    mag = v[33] ? 34'(-v) : v;
  endfunction

  assign adx = mag(ddx);
  assign ady = mag(ddy);

  // adaptive lookahead, base plus a fifth of the nearest distance, clamped
  logic [43:0] fifth_prod;
  logic [63:0] la_adapt;
  always_comb begin
    fifth_prod = 44'(dmin[21:0]) * 44'(FIFTH_MUL);
    la_adapt   = 64'(la_base) + 64'(fifth_prod[43:24]);
    if (dmin >= FIFTH_LIMIT || la_adapt > 64'(la_max)) la_adapt = 64'(la_max);
    if (la_adapt < 64'(la_min)) la_adapt = 64'(la_min);
  end

  // speed from target distance, clamped to max then raised to min
  logic [63:0] spd_calc;
  always_comb begin
    spd_calc = sq_root + (sq_root >> 1);
    if (spd_calc > 64'(spd_max)) spd_calc = 64'(spd_max);
    if (spd_calc < 64'(spd_min)) spd_calc = 64'(spd_min);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      busy       <= 1'b0;
      res_strobe <= 1'b0;
      la_base    <= CfgW'(19661);
      la_min     <= CfgW'(9830);
      la_max     <= CfgW'(32768);
      spd_max    <= CfgW'(16384);
      spd_min    <= CfgW'(1311);
      adaptive   <= 1'b1;
      point_count <= '0;
      we         <= 1'b0;
      mpass      <= 2'd0;
      sq_req.go  <= 1'b0;
      sq_req.b   <= '0;
      dv_req.go  <= 1'b0;
    end else begin
      res_strobe <= 1'b0;
      we         <= 1'b0;
      sq_req.go  <= 1'b0;
      dv_req.go  <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          REG_LA_BASE:  la_base  <= cfg_data[CfgW-1:0];
          REG_LA_MIN:   la_min   <= cfg_data[CfgW-1:0];
          REG_LA_MAX:   la_max   <= cfg_data[CfgW-1:0];
          REG_SPD_MAX:  spd_max  <= cfg_data[CfgW-1:0];
          REG_SPD_MIN:  spd_min  <= cfg_data[CfgW-1:0];
          REG_ADAPTIVE: adaptive <= cfg_data[0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          busy <= 1'b0;
          if (start && !busy) begin
            cx <= in_item.coord_x;
            cy <= in_item.coord_y;
            if (in_item.operation == OP_LOAD) begin
              if (32'(in_item.point_index) < MAX_POINTS) begin
                we    <= 1'b1;
                addr  <= AW'(in_item.point_index);
                wdata <= {in_item.coord_x, in_item.coord_y};
                if (in_item.point_last) point_count <= LW'(in_item.point_index) + LW'(1);
              end
              busy <= 1'b1;
            end else begin
              busy <= 1'b1;
              if (point_count < LW'(2)) begin
                res_item   <= '0;
                res_strobe <= 1'b1;
              end else begin
                last    <= point_count - LW'(1);
                idx     <= '0;
                nearest <= '0;
                first   <= 1'b1;
                state   <= S_SCAN_RD;
              end
            end
          end
        end
        // nearest-point scan
        S_SCAN_RD: begin
          addr  <= AW'(idx);
          state <= S_SCAN_WT;
        end
        S_SCAN_WT: state <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (mpass == 2'd0) begin
            ddx   <= 34'(signed'(rdata[63:32])) - 34'(cx);
            ddy   <= 34'(signed'(rdata[31:0])) - 34'(cy);
            mpass <= 2'd1;
          end else if (mpass == 2'd1) begin
            sqx   <= 66'(adx) * 66'(adx);
            sqy   <= 66'(ady) * 66'(ady);
            mpass <= 2'd2;
          end else begin
            mpass <= 2'd0;
            if (first || 65'(sqx + sqy) < best) begin
              best    <= 65'(sqx + sqy);
              nearest <= idx;
            end
            first <= 1'b0;
            if (idx == last) begin
              state <= S_NEAR_SQ;
            end else begin
              idx   <= idx + LW'(1);
              state <= S_SCAN_RD;
            end
          end
        end
        S_NEAR_SQ: begin
          sq_req.go <= 1'b1;
          sq_req.a  <= 128'(best);
          state     <= S_NEAR_WT;
        end
        S_NEAR_WT: if (sq_done) begin
          dmin  <= sq_root;
          addr  <= AW'(last);
          state <= S_END_WT;
        end
        S_END_RD: state <= S_END_WT;
        S_END_WT: state <= S_END_SQ;
        S_END_SQ: begin
          if (mpass == 2'd0) begin
            tx    <= 33'(signed'(rdata[63:32]));
            ty    <= 33'(signed'(rdata[31:0]));
            ddx   <= 34'(signed'(rdata[63:32])) - 34'(cx);
            ddy   <= 34'(signed'(rdata[31:0])) - 34'(cy);
            mpass <= 2'd1;
          end else if (mpass == 2'd1) begin
            sqx   <= 66'(adx) * 66'(adx);
            sqy   <= 66'(ady) * 66'(ady);
            mpass <= 2'd2;
          end else begin
            mpass     <= 2'd0;
            sq_req.go <= 1'b1;
            sq_req.a  <= 128'(65'(sqx + sqy));
            state     <= S_END_DONE;
          end
        end
        S_END_DONE: if (sq_done) begin
          dend <= sq_root;
          la   <= adaptive ? la_adapt : 64'(la_base);
          cum  <= '0;
          idx  <= nearest;
          if (last == LW'(1) || sq_root < END_NEAR || nearest == last)
            state <= S_ERR_SQ;
          else
            state <= S_WALK_RD0;
        end
        // segment walk
        S_WALK_RD0: begin
          addr  <= AW'(idx);
          state <= S_WALK_WT0;
        end
        S_WALK_WT0: begin
          addr  <= AW'(idx + LW'(1));
          state <= S_WALK_RD1;
        end
        S_WALK_RD1: begin
          px    <= signed'(rdata[63:32]);
          py    <= signed'(rdata[31:0]);
          state <= S_WALK_WT1;
        end
        S_WALK_WT1: begin
          ddx   <= 34'(signed'(rdata[63:32])) - 34'(px);
          ddy   <= 34'(signed'(rdata[31:0])) - 34'(py);
          state <= S_SEG_SQ;
        end
        S_SEG_SQ: begin
          if (mpass == 2'd0) begin
            sqx   <= 66'(adx) * 66'(adx);
            sqy   <= 66'(ady) * 66'(ady);
            mpass <= 2'd1;
          end else begin
            mpass     <= 2'd0;
            sq_req.go <= 1'b1;
            sq_req.a  <= 128'(65'(sqx + sqy));
            state     <= S_SEG_CHK;
          end
        end
        S_SEG_CHK: if (sq_done) begin
          seg <= sq_root;
          if (sq_root == '0) begin
            if (idx + LW'(1) == last) state <= S_ERR_SQ;
            else begin idx <= idx + LW'(1); state <= S_WALK_RD0; end
          end else if (cum + sq_root >= la) begin
            rem_la    <= CfgW'(la - cum);
            neg       <= ddx[33];
            dv_req.go <= 1'b1;
            dv_req.a  <= 128'(53'(adx) * 53'(CfgW'(la - cum)));
            dv_req.b  <= sq_root;
            state     <= S_IX_DIV;
          end else begin
            cum <= cum + sq_root;
            if (idx + LW'(1) == last) state <= S_ERR_SQ;
            else begin idx <= idx + LW'(1); state <= S_WALK_RD0; end
          end
        end
        S_IX_DIV: if (dv_done) begin
          tx        <= 33'(px) + (neg ? -33'(dv_quot[32:0]) : 33'(dv_quot[32:0]));
          neg       <= ddy[33];
          dv_req.go <= 1'b1;
          dv_req.a  <= 128'(53'(ady) * 53'(rem_la));
          dv_req.b  <= seg;
          state     <= S_IY_DIV;
        end
        S_IY_DIV: if (dv_done) begin
          ty    <= 33'(py) + (neg ? -33'(dv_quot[32:0]) : 33'(dv_quot[32:0]));
          state <= S_ERR_SQ;
        end
        // target distance and speed
        S_ERR_SQ: begin
          if (mpass == 2'd0) begin
            ddx   <= 34'(tx) - 34'(cx);
            ddy   <= 34'(ty) - 34'(cy);
            mpass <= 2'd1;
          end else if (mpass == 2'd1) begin
            sqx   <= 66'(adx) * 66'(adx);
            sqy   <= 66'(ady) * 66'(ady);
            mpass <= 2'd2;
          end else begin
            mpass     <= 2'd0;
            sq_req.go <= 1'b1;
            sq_req.a  <= 128'(65'(sqx + sqy));
            state     <= S_ERR_CHK;
          end
        end
        S_ERR_CHK: if (sq_done) begin
          derr <= sq_root;
          res_item.valid_res       <= 1'b1;
          res_item.distance_to_end <= (dend > 64'h7FFFFFFF) ? 31'h7FFFFFFF : dend[30:0];
          res_item.vel_x <= '0;
          res_item.vel_y <= '0;
          if (sq_root < STOP_NEAR) state <= S_OUT;
          else begin
            spd       <= spd_calc[CfgW-1:0];
            neg       <= ddx[33];
            dv_req.go <= 1'b1;
            dv_req.a  <= 128'(53'(adx) * 53'(spd_calc[CfgW-1:0]));
            dv_req.b  <= sq_root;
            state     <= S_VX_DIV;
          end
        end
        S_VX_DIV: if (dv_done) begin
          res_item.vel_x <= neg ? -dv_quot[31:0] : dv_quot[31:0];
          neg       <= ddy[33];
          dv_req.go <= 1'b1;
          dv_req.a  <= 128'(53'(ady) * 53'(spd));
          dv_req.b  <= derr;
          state     <= S_VY_DIV;
        end
        S_VY_DIV: if (dv_done) begin
          res_item.vel_y <= neg ? -dv_quot[31:0] : dv_quot[31:0];
          state          <= S_OUT;
        end
        S_OUT: begin
          res_strobe <= 1'b1;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result strobe is never held high
  assert property (@(posedge clk) disable iff (rst) res_strobe |=> !res_strobe)
    else $error("result strobe held");
  // a result is only shown while an item is in flight
  assert property (@(posedge clk) disable iff (rst) res_strobe |-> busy)
    else $error("result without item");
  // divider and sqrt are never started together
  assert property (@(posedge clk) disable iff (rst) !(sq_req.go && dv_req.go))
    else $error("units started together");
endmodule

[bench/tb_lookahead_path_follower.sv]
// tb_lookahead_path_follower: self-checking bench for the lookahead path follower
// depends on lpf_pkg and the lookahead_path_follower rtl; predicts most results in-bench
module tb_lookahead_path_follower import lpf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      res_strobe;
  out_item_t res_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  // bench copy of the block state
  logic signed [31:0] wp_x [256];
  logic signed [31:0] wp_y [256];
  bit                 wp_written [256];
  logic [8:0]         point_count;
  logic [18:0] la_base, la_min, la_max, spd_max, spd_min;
  bit          adaptive;

  out_item_t pending_cmds [$];
  bit        failed;
  int        sent;
  int        idle_pct;

  lookahead_path_follower dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .res_strobe(res_strobe), .res_item(res_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("lookahead_path_follower: mismatch");
    $finish;
  end

  // integer square root, floor
  function automatic logic [127:0] isqrt(input logic [127:0] v);
    logic [127:0] r, b;
    r = '0;
    b = 128'd1 << 126;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [127:0] mag(input longint v);
    return v < 0 ? 128'(-v) : 128'(v);
  endfunction

  function automatic logic [127:0] sq_sum(input longint dx, input longint dy);
    return mag(dx) * mag(dx) + mag(dy) * mag(dy);
  endfunction

  function automatic logic [127:0] root_of(input logic [127:0] s);
    if (s >= (128'd1 << 64)) return 2 * isqrt(s >> 2);
    return isqrt(s);
  endfunction

  function automatic logic [127:0] span(input longint dx, input longint dy);
    return root_of(sq_sum(dx, dy));
  endfunction

  // signed v times m over d, truncated toward zero
  function automatic longint scaled(input longint v, input logic [127:0] m,
                                    input logic [127:0] d);
    logic [127:0] q;
    q = (mag(v) * m) / d;
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  // velocity command for a car pose against the stored path
  function automatic out_item_t pursuit_cmd(input longint cx, input longint cy);
    out_item_t    o;
    int           n, last, nearest;
    logic [127:0] best, w, dmin, dend, derr, la, cum, seg, rem, spd, v;
    longint       tx, ty, sx, sy, dx, dy;
    o = '0;
    n = point_count;
    if (n < 2) return o;
    last = n - 1;
    nearest = 0;
    best = sq_sum(longint'(wp_x[0]) - cx, longint'(wp_y[0]) - cy);
    for (int i = 1; i < n; i++) begin
      w = sq_sum(longint'(wp_x[i]) - cx, longint'(wp_y[i]) - cy);
      if (w < best) begin
        best = w;
        nearest = i;
      end
    end
    dmin = root_of(best);
    dend = span(longint'(wp_x[last]) - cx, longint'(wp_y[last]) - cy);
    tx = wp_x[last];
    ty = wp_y[last];
    if (n != 2 && dend >= 32768) begin
      la = la_base;
      cum = 0;
      if (adaptive) begin
        v = la + dmin / 5;
        if (v > la_max) v = la_max;
        if (v < la_min) v = la_min;
        la = v;
      end
      for (int i = nearest; i < last; i++) begin
        sx = longint'(wp_x[i+1]) - longint'(wp_x[i]);
        sy = longint'(wp_y[i+1]) - longint'(wp_y[i]);
        seg = span(sx, sy);
        if (seg == 0) continue;
        if (cum + seg >= la) begin
          rem = la - cum;
          tx = longint'(wp_x[i]) + scaled(sx, rem, seg);
          ty = longint'(wp_y[i]) + scaled(sy, rem, seg);
          break;
        end
        cum = cum + seg;
      end
    end
    o.valid_res = 1'b1;
    o.distance_to_end = dend > 128'h7FFF_FFFF ? 31'h7FFF_FFFF : dend[30:0];
    dx = tx - cx;
    dy = ty - cy;
    derr = span(dx, dy);
    if (derr < 66) return o;
    spd = derr + derr / 2;
    if (spd > spd_max) spd = spd_max;
    if (spd < spd_min) spd = spd_min;
    o.vel_x = 32'(scaled(dx, spd, derr));
    o.vel_y = 32'(scaled(dy, spd, derr));
    return o;
  endfunction

  function automatic in_item_t wp_beat(input int idx, input bit fin, input int x, input int y);
    in_item_t t;
    t.operation = OP_LOAD;
    t.point_index = idx[7:0];
    t.point_last = fin;
    t.coord_x = x;
    t.coord_y = y;
    return t;
  endfunction

  function automatic in_item_t pose_beat(input int x, input int y);
    in_item_t t;
    t = '0;
    t.operation = OP_POSE;
    t.point_index = 8'($urandom);
    t.point_last = 1'($urandom);
    t.coord_x = x;
    t.coord_y = y;
    return t;
  endfunction

  // a pose may only be sent when every slot it scans has been written
  function automatic bit path_readable();
    if (point_count < 2) return 1'b1;
    for (int i = 0; i < point_count; i++) if (!wp_written[i]) return 1'b0;
    return 1'b1;
  endfunction

  // drive one beat; update the bench state and queue the expected command
  task automatic send(input in_item_t t, input bit typed = 0, input out_item_t want = '0);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= t;
    do @(posedge clk); while (busy);
    sent++;
    if (t.operation == OP_LOAD) begin
      wp_x[t.point_index] = t.coord_x;
      wp_y[t.point_index] = t.coord_y;
      wp_written[t.point_index] = 1'b1;
      if (t.point_last) point_count = 9'(t.point_index) + 9'd1;
    end else begin
      pending_cmds.push_back(typed ? want : pursuit_cmd(t.coord_x, t.coord_y));
    end
  endtask

  // register write, only once the block has drained
  task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
    start <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LA_BASE:  la_base  = val[18:0];
      REG_LA_MIN:   la_min   = val[18:0];
      REG_LA_MAX:   la_max   = val[18:0];
      REG_SPD_MAX:  spd_max  = val[18:0];
      REG_SPD_MIN:  spd_min  = val[18:0];
      REG_ADAPTIVE: adaptive = val[0];
      default: ;
    endcase
  endtask

  function automatic int near_coord(input int c, input int spread);
    return c + $signed($urandom_range(2 * spread)) - spread;
  endfunction

  // well-formed path followed by a few poses near it
  task automatic path_and_poses();
    int k, x, y, px, py, step;
    k = ($urandom_range(19) == 0) ? $urandom_range(13, 48) : $urandom_range(2, 10);
    x = near_coord(0, 262144);
    y = near_coord(0, 262144);
    step = ($urandom_range(3) == 0) ? 131072 : 32768;
    for (int i = 0; i < k; i++) begin
      send(wp_beat(i, i == k - 1, x, y));
      if ($urandom_range(7) != 0) begin
        x = near_coord(x, step);
        y = near_coord(y, step);
      end
    end
    repeat ($urandom_range(1, 4)) begin
      px = wp_x[$urandom_range(k - 1)];
      py = wp_y[$urandom_range(k - 1)];
      send(pose_beat(near_coord(px, 65536), near_coord(py, 65536)));
    end
  endtask

  // noise: stray loads anywhere and poses at any coordinate
  task automatic noise_beat();
    if ($urandom_range(1) == 0 && path_readable())
      send(pose_beat($urandom, $urandom));
    else
      send(wp_beat($urandom_range(255), $urandom_range(9) == 0, $urandom, $urandom));
  endtask

  task automatic random_phase(input int count);
    int stop_at;
    stop_at = sent + count;
    while (sent < stop_at) begin
      if ($urandom_range(4) == 0) noise_beat();
      else path_and_poses();
    end
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t w;
    if (!rst && res_strobe) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected result %p", $time, res_item);
        failed = 1'b1;
      end else begin
        w = pending_cmds.pop_front();
        if (res_item.valid_res !== w.valid_res) begin
          $display("%0t: valid_res exp %0d got %0d", $time, w.valid_res, res_item.valid_res);
          failed = 1'b1;
        end
        if (res_item.vel_x !== w.vel_x) begin
          $display("%0t: vel_x exp %0d got %0d", $time, w.vel_x, res_item.vel_x);
          failed = 1'b1;
        end
        if (res_item.vel_y !== w.vel_y) begin
          $display("%0t: vel_y exp %0d got %0d", $time, w.vel_y, res_item.vel_y);
          failed = 1'b1;
        end
        if (res_item.distance_to_end !== w.distance_to_end) begin
          $display("%0t: distance_to_end exp %0d got %0d", $time, w.distance_to_end,
                   res_item.distance_to_end);
          failed = 1'b1;
        end
      end
    end
  end

  // stimulus
  initial begin
    dir_row_t rows [$];
    rst = 1'b1;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    failed = 1'b0;
    sent = 0;
    idle_pct = 36;
    point_count = '0;
    la_base = 19661; la_min = 9830; la_max = 32768;
    spd_max = 16384; spd_min = 1311; adaptive = 1'b1;
    foreach (wp_written[i]) wp_written[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty path, two-point path, extremes, zero-length segment, walk exhausted
    rows.push_back('{pose_beat(0, 0), 1, '0});
    rows.push_back('{wp_beat(0, 0, 0, 0), 0, '0});
    rows.push_back('{pose_beat(0, 0), 1, '0});
    rows.push_back('{wp_beat(1, 1, 131072, 0), 0, '0});
    rows.push_back('{pose_beat(0, 0), 1, '{1'b1, 32'sd16384, 32'sd0, 31'd131072}});
    rows.push_back('{pose_beat(131072, 0), 1, '{1'b1, 32'sd0, 32'sd0, 31'd0}});
    rows.push_back('{wp_beat(0, 0, 32'h8000_0000, 32'h8000_0000), 0, '0});
    rows.push_back('{wp_beat(1, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 0, '0});
    rows.push_back('{pose_beat(32'h7FFF_FFFF, 32'h8000_0000), 0, '0});
    rows.push_back('{pose_beat(32'h8000_0000, 32'h8000_0000), 0, '0});
    rows.push_back('{wp_beat(0, 0, 0, 0), 0, '0});
    rows.push_back('{wp_beat(1, 0, 0, 0), 0, '0});
    rows.push_back('{wp_beat(2, 0, 65536, 0), 0, '0});
    rows.push_back('{wp_beat(3, 1, 131072, 65536), 0, '0});
    rows.push_back('{pose_beat(0, 6553), 0, '0});
    rows.push_back('{pose_beat(-200000, 0), 0, '0});
    rows.push_back('{pose_beat(131072, 65580), 0, '0});
    rows.push_back('{wp_beat(255, 0, -1, 1), 0, '0});
    rows.push_back('{wp_beat(4, 1, 131072, 65536), 0, '0});
    rows.push_back('{pose_beat(100000, 60000), 0, '0});
    foreach (rows[i]) send(rows[i].item, rows[i].typed, rows[i].want);

    // phase one: large base lookahead with adaptive off, then adaptive on with clamps crossed
    write_reg(REG_ADAPTIVE, 0);
    write_reg(REG_LA_BASE, 262144);
    random_phase(45);
    write_reg(REG_ADAPTIVE, 1);
    write_reg(REG_LA_MIN, 262144);
    write_reg(REG_LA_MAX, 0);
    write_reg(REG_SPD_MAX, 0);
    write_reg(REG_SPD_MIN, 262144);
    random_phase(45);

    // phase two: sender idles more, zero base and minimum lookahead and speed extremes
    idle_pct = 49;
    write_reg(REG_LA_BASE, 0);
    write_reg(REG_LA_MIN, 0);
    write_reg(REG_LA_MAX, 262144);
    write_reg(REG_SPD_MAX, 262144);
    write_reg(REG_SPD_MIN, 0);
    random_phase(90);

    // phase three: no idling, random settings
    idle_pct = 0;
    write_reg(REG_LA_BASE, $urandom_range(65536));
    write_reg(REG_LA_MIN, $urandom_range(16384));
    write_reg(REG_LA_MAX, $urandom_range(16384, 131072));
    write_reg(REG_SPD_MAX, $urandom_range(8192, 65536));
    write_reg(REG_SPD_MIN, $urandom_range(4096));
    write_reg(REG_ADAPTIVE, $urandom_range(1));
    random_phase(90);

    start <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (!failed)
      $display("lookahead_path_follower: match");
    else
      $display("lookahead_path_follower: mismatch");
    $finish;
  end

endmodule
